### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is high.
`define MF3_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define MF3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mf3_pkg.sv
// Types, constants and the compare-exchange network of the 3x3 median filter.
package mf3_pkg;

   localparam int unsigned WINDOW_DIM   = 3;
   localparam int unsigned WIN_COUNT    = WINDOW_DIM * WINDOW_DIM;
   localparam int unsigned NUM_CHANNELS = 3;
   localparam int unsigned SAMPLE_W     = 8;
   localparam int unsigned PIXEL_W      = SAMPLE_W * NUM_CHANNELS;
   localparam int unsigned WIN_IDX_W    = $clog2(WIN_COUNT);
   localparam int unsigned MEDIAN_POS   = WIN_COUNT / 2;

   // Nine network levels padded with one empty level to fill the last stage.
   localparam int unsigned NET_LEVELS       = 10;
   localparam int unsigned NET_PAIRS        = 3;
   localparam int unsigned LEVELS_PER_STAGE = 2;
   localparam int unsigned NUM_STAGES       = NET_LEVELS / LEVELS_PER_STAGE;
   localparam int unsigned LEVEL_IDX_W      = $clog2(NET_LEVELS);

   typedef logic [SAMPLE_W-1:0]                   sample_type;
   typedef logic [PIXEL_W-1:0]                    pixel_type;
   typedef logic [WIN_IDX_W-1:0]                  win_idx_type;
   typedef logic [LEVEL_IDX_W-1:0]                level_idx_type;
   typedef sample_type [WIN_COUNT-1:0]            win_type;
   typedef win_type [NUM_CHANNELS-1:0]            chan_win_type;

   // Each pair leaves the smaller sample at the first index, the larger at the second.
   // A pair of one index with itself does nothing.
   localparam win_idx_type NET_LO [NET_LEVELS][NET_PAIRS] = '{
      '{4'd1, 4'd4, 4'd7},
      '{4'd0, 4'd3, 4'd6},
      '{4'd1, 4'd4, 4'd7},
      '{4'd0, 4'd5, 4'd4},
      '{4'd3, 4'd1, 4'd2},
      '{4'd4, 4'd0, 4'd0},
      '{4'd4, 4'd0, 4'd0},
      '{4'd6, 4'd0, 4'd0},
      '{4'd4, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0}
   };

   localparam win_idx_type NET_HI [NET_LEVELS][NET_PAIRS] = '{
      '{4'd2, 4'd5, 4'd8},
      '{4'd1, 4'd4, 4'd7},
      '{4'd2, 4'd5, 4'd8},
      '{4'd3, 4'd8, 4'd7},
      '{4'd6, 4'd4, 4'd5},
      '{4'd7, 4'd0, 4'd0},
      '{4'd2, 4'd0, 4'd0},
      '{4'd4, 4'd0, 4'd0},
      '{4'd2, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0}
   };

   // One level of the network: disjoint pairs, each a compare and swap.
   function automatic win_type cx_level(input win_type s, input level_idx_type lvl);
      win_type    r;
      sample_type a;
      sample_type b;
      r = s;
      for (int unsigned p = 0; p < NET_PAIRS; p++) begin
         a = r[NET_LO[lvl][p]];
         b = r[NET_HI[lvl][p]];
         r[NET_LO[lvl][p]] = (a > b) ? b : a;
         r[NET_HI[lvl][p]] = (a > b) ? a : b;
      end
      return r;
   endfunction

endpackage

### rtl/mf3_if.sv
// Request and response channel interfaces of the 3x3 median filter.
interface mf3_req_if;
   import mf3_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type window_pixel_0;
   pixel_type window_pixel_1;
   pixel_type window_pixel_2;
   pixel_type window_pixel_3;
   pixel_type window_pixel_4;
   pixel_type window_pixel_5;
   pixel_type window_pixel_6;
   pixel_type window_pixel_7;
   pixel_type window_pixel_8;

   modport source (
      output valid, window_pixel_0, window_pixel_1, window_pixel_2,
             window_pixel_3, window_pixel_4, window_pixel_5,
             window_pixel_6, window_pixel_7, window_pixel_8,
      input  ready
   );
   modport sink (
      input  valid, window_pixel_0, window_pixel_1, window_pixel_2,
             window_pixel_3, window_pixel_4, window_pixel_5,
             window_pixel_6, window_pixel_7, window_pixel_8,
      output ready
   );
endinterface

interface mf3_rsp_if;
   import mf3_pkg::*;
   logic       valid;
   logic       ready;
   sample_type median_blue;
   sample_type median_green;
   sample_type median_red;

   modport source (
      output valid, median_blue, median_green, median_red,
      input  ready
   );
   modport sink (
      input  valid, median_blue, median_green, median_red,
      output ready
   );
endinterface

### rtl/median_filter_3x3_rgb.sv
// Each request passes through 5 register stages before its response is valid.
// Throughput: one window per cycle unless the response side stalls; each stage runs two levels of the median network.
// A stalled response holds the last stage; earlier stages keep filling bubbles.
// Reset (synchronous, active high) clears the stage valid bits only.
// Data registers carry no reset.
module median_filter_3x3_rgb (
   input logic    clock,
   input logic    reset,
   mf3_req_if.sink   req_ch,
   mf3_rsp_if.source rsp_ch
);
   import mf3_pkg::*;

   pixel_type    pix [WIN_COUNT];
   chan_win_type win_in;

   chan_win_type data_ff  [NUM_STAGES];
   logic         valid_ff [NUM_STAGES];
   logic         stage_ready [NUM_STAGES];

   assign pix[0] = req_ch.window_pixel_0;
   assign pix[1] = req_ch.window_pixel_1;
   assign pix[2] = req_ch.window_pixel_2;
   assign pix[3] = req_ch.window_pixel_3;
   assign pix[4] = req_ch.window_pixel_4;
   assign pix[5] = req_ch.window_pixel_5;
   assign pix[6] = req_ch.window_pixel_6;
   assign pix[7] = req_ch.window_pixel_7;
   assign pix[8] = req_ch.window_pixel_8;

   // Split each pixel into its blue, green and red samples.
   always_comb begin
      for (int unsigned c = 0; c < NUM_CHANNELS; c++) begin
         for (int unsigned k = 0; k < WIN_COUNT; k++) begin
            win_in[c][k] = pix[k][c*SAMPLE_W +: SAMPLE_W];
         end
      end
   end

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      chan_win_type src;
      chan_win_type mid;
      chan_win_type data_in;
      logic         valid_in;
      logic         down_ready;

      if (g == 0) begin : g_first
         assign src      = win_in;
         assign valid_in = req_ch.valid;
      end else begin : g_next
         assign src      = data_ff[g-1];
         assign valid_in = valid_ff[g-1];
      end

      if (g == NUM_STAGES - 1) begin : g_last
         assign down_ready = rsp_ch.ready;
      end else begin : g_mid
         assign down_ready = stage_ready[g+1];
      end

      // Advance when empty or when the next stage takes the current request.
      assign stage_ready[g] = !valid_ff[g] || down_ready;

      always_comb begin
         for (int unsigned c = 0; c < NUM_CHANNELS; c++) begin
            mid[c]     = cx_level(src[c], level_idx_type'(LEVELS_PER_STAGE * g));
            data_in[c] = cx_level(mid[c], level_idx_type'(LEVELS_PER_STAGE * g + 1));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (stage_ready[g]) begin
            valid_ff[g] <= valid_in;
         end
         if (stage_ready[g]) begin
            data_ff[g] <= data_in;
         end
      end
   end

   assign req_ch.ready        = stage_ready[0];
   assign rsp_ch.valid        = valid_ff[NUM_STAGES-1];
   assign rsp_ch.median_blue  = data_ff[NUM_STAGES-1][0][MEDIAN_POS];
   assign rsp_ch.median_green = data_ff[NUM_STAGES-1][1][MEDIAN_POS];
   assign rsp_ch.median_red   = data_ff[NUM_STAGES-1][2][MEDIAN_POS];

endmodule

### rtl/mf3_checker.sv
// Port-level checker for the 3x3 median filter, bound to the top level.
`include "assert_macros.svh"

module mf3_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mf3_pkg::sample_type   rsp_blue,
   input mf3_pkg::sample_type   rsp_green,
   input mf3_pkg::sample_type   rsp_red
);
   import mf3_pkg::*;

   // The pipeline is empty right after reset.
   `MF3_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !rsp_valid, "response valid after reset")

   // An empty output stage must never back-pressure the request side.
   `MF3_ASSERT(a_ready_when_drained, clock, reset, !rsp_valid |-> req_ready, "request stalled with no response pending")

   // A stalled response holds.
   `MF3_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   `MF3_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_blue) && $stable(rsp_green) && $stable(rsp_red), "response changed while stalled")

endmodule

bind median_filter_3x3_rgb mf3_checker u_mf3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_blue  (rsp_ch.median_blue),
   .rsp_green (rsp_ch.median_green),
   .rsp_red   (rsp_ch.median_red)
);

### test/mf3_median_checker.sv
// Checker for the 3x3 median filter: predicts per-channel medians and compares responses.
`timescale 1ns / 1ps

module mf3_median_checker (
   input  logic clock,
   input  logic reset,
   mf3_req_if   req_mon,
   mf3_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   medians_due
);
   import mf3_pkg::*;

   localparam int BLUE_LANE  = 0;
   localparam int GREEN_LANE = 1;
   localparam int RED_LANE   = 2;

   typedef struct packed {
      sample_type blue;
      sample_type green;
      sample_type red;
   } rgb_median_type;

   rgb_median_type median_queue[$];

   // Fifth smallest of nine, equal samples counted separately.
   function automatic sample_type fifth_smallest(input sample_type s[WIN_COUNT]);
      sample_type sorted[WIN_COUNT];
      sample_type v;
      int         j;
      sorted = s;
      for (int i = 1; i < WIN_COUNT; i++) begin
         v = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      return sorted[MEDIAN_POS];
   endfunction

   function automatic rgb_median_type window_medians(input pixel_type win[WIN_COUNT]);
      sample_type     lane[WIN_COUNT];
      rgb_median_type m;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         for (int k = 0; k < WIN_COUNT; k++) begin
            lane[k] = win[k][ch*SAMPLE_W +: SAMPLE_W];
         end
         if (ch == BLUE_LANE) begin
            m.blue = fifth_smallest(lane);
         end else if (ch == GREEN_LANE) begin
            m.green = fifth_smallest(lane);
         end else if (ch == RED_LANE) begin
            m.red = fifth_smallest(lane);
         end
      end
      return m;
   endfunction

   always @(posedge clock) begin : watch
      pixel_type      win[WIN_COUNT];
      rgb_median_type want;
      rgb_median_type got;
      if (reset) begin
         mismatch_count <= 0;
         medians_due    <= 0;
         median_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            win[0] = req_mon.window_pixel_0;
            win[1] = req_mon.window_pixel_1;
            win[2] = req_mon.window_pixel_2;
            win[3] = req_mon.window_pixel_3;
            win[4] = req_mon.window_pixel_4;
            win[5] = req_mon.window_pixel_5;
            win[6] = req_mon.window_pixel_6;
            win[7] = req_mon.window_pixel_7;
            win[8] = req_mon.window_pixel_8;
            median_queue.push_back(window_medians(win));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.blue  = rsp_mon.median_blue;
            got.green = rsp_mon.median_green;
            got.red   = rsp_mon.median_red;
            if (median_queue.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: response without request: b=%02h g=%02h r=%02h",
                           $realtime, got.blue, got.green, got.red);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = median_queue.pop_front();
               if (got.blue !== want.blue || got.green !== want.green ||
                   got.red !== want.red) begin
                  if (mismatch_count < 10) begin
                     $display({"%0t: median mismatch: expected b=%02h g=%02h r=%02h,",
                               " got b=%02h g=%02h r=%02h"},
                              $realtime, want.blue, want.green, want.red,
                              got.blue, got.green, got.red);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         medians_due <= median_queue.size();
      end
   end

endmodule

### test/tb_median_filter_3x3_rgb.sv
// Top of the 3x3 median filter testbench: clock, reset, window requests and the verdict.
`timescale 1ns / 1ps

module tb_median_filter_3x3_rgb;
   import mf3_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int SEGMENT_ITEMS = 50;
   localparam int DRAIN_CYCLES  = 10;

   typedef enum int {MIX_FULL, MIX_TIES, MIX_EXTREME, MIX_NEAR, MIX_FLAT} window_mix_type;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   medians_due;
   int   stall_cycles;

   mf3_req_if req_ch();
   mf3_rsp_if rsp_ch();

   median_filter_3x3_rgb uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mf3_median_checker median_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .medians_due    (medians_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("FAIL median_filter_3x3_rgb");
      $finish;
   end

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, 9);
   endfunction

   task automatic load_window(input pixel_type w[WIN_COUNT]);
      req_ch.window_pixel_0 <= w[0];
      req_ch.window_pixel_1 <= w[1];
      req_ch.window_pixel_2 <= w[2];
      req_ch.window_pixel_3 <= w[3];
      req_ch.window_pixel_4 <= w[4];
      req_ch.window_pixel_5 <= w[5];
      req_ch.window_pixel_6 <= w[6];
      req_ch.window_pixel_7 <= w[7];
      req_ch.window_pixel_8 <= w[8];
   endtask

   // Hold the request until the filter takes it.
   task automatic send_window(input pixel_type w[WIN_COUNT], input int gap);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      load_window(w);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_medians();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (medians_due != 0) @(posedge clock);
   endtask

   // Response side: random stalls, with stall-free stretches.
   initial begin : response_sink
      int  gap;
      int  taken;
      bit  burst;
      rsp_ch.ready <= 1'b0;
      taken = 0;
      burst = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % SEGMENT_ITEMS == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         gap = draw_gap(burst);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   initial begin : stimulus
      pixel_type      win[WIN_COUNT];
      window_mix_type mix;
      sample_type     v;
      sample_type     base;
      int             j;
      bit             burst;
      for (int k = 0; k < WIN_COUNT; k++) begin
         win[k] = '0;
      end
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      load_window(win);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int d = 0; d < 21; d++) begin
         j = 0;
         for (int k = 0; k < WIN_COUNT; k++) begin
            case (d)
               0:  win[k] = 24'h000000;
               1:  win[k] = 24'hFFFFFF;
               2:  win[k] = (k % 2 == 0) ? 24'hFFFFFF : 24'h000000;
               3:  win[k] = (k % 2 == 1) ? 24'hFFFFFF : 24'h000000;
               4:  win[k] = {3{8'(k * 30)}};
               5:  win[k] = {3{8'(255 - k * 30)}};
               6:  win[k] = {8'h80, 8'(255 - k * 28), 8'(k * 28)};
               7:  win[k] = (k == 0) ? 24'($urandom) : win[0];
               17: win[k] = (k == 4) ? 24'hAAAAAA : 24'h555555;
               18: win[k] = (k < 5) ? 24'hAAAAAA : 24'h555555;
               19: win[k] = {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                             $urandom_range(0, 1) ? 8'hFF : 8'h00,
                             $urandom_range(0, 1) ? 8'hFF : 8'h00};
               20: win[k] = {8'($urandom), 8'hFF, 8'h00};
               default: begin
                  // Place the lone middle value at each position in turn.
                  if (k == d - 8) begin
                     win[k] = 24'h807F81;
                  end else begin
                     win[k] = (j < 4) ? 24'h102030 : 24'hF0E0D0;
                     j++;
                  end
               end
            endcase
         end
         send_window(win, draw_gap(d < 10));
      end
      drain_medians();

      burst = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_ITEMS == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2) begin
            drain_medians();
         end
         mix = window_mix_type'($urandom_range(0, 4));
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            base = 8'($urandom);
            for (int k = 0; k < WIN_COUNT; k++) begin
               case (mix)
                  MIX_FULL:    v = 8'($urandom);
                  MIX_TIES:    v = 8'($urandom_range(0, 3) * 85);
                  MIX_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  MIX_NEAR:    v = base + 8'($urandom_range(0, 4));
                  default:     v = base;
               endcase
               win[k][ch*SAMPLE_W +: SAMPLE_W] = v;
            end
         end
         send_window(win, draw_gap(burst));
      end

      drain_medians();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && medians_due == 0) begin
         $display("PASS median_filter_3x3_rgb");
      end else begin
         $display("FAIL median_filter_3x3_rgb");
      end
      $finish;
   end

endmodule
